/* src/ccm_pkg.sv */
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants of the complementary color matcher
// Holds the request and result payload structs and the configuration indexes.
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam int FIELD_W = 17;

    typedef struct packed {
        logic [FIELD_W-1:0] probe_red;
        logic [FIELD_W-1:0] probe_green;
        logic [FIELD_W-1:0] probe_blue;
        logic               use_complement;
    } t_request;

    typedef struct packed {
        logic               is_match;
        logic [FIELD_W-1:0] checked_red;
        logic [FIELD_W-1:0] checked_green;
        logic [FIELD_W-1:0] checked_blue;
    } t_result;

    typedef enum logic [1:0] {
        CFG_REF_RED   = 2'd0,
        CFG_REF_GREEN = 2'd1,
        CFG_REF_BLUE  = 2'd2,
        CFG_TOLERANCE = 2'd3
    } t_cfg_index;

    localparam logic [FIELD_W-1:0] TOLERANCE_RESET = 17'd6554;

endpackage

/* src/ccm_divider.sv */
// ----------------------------------------------------------------------------
// ccm_divider: pipelined restoring divider
// Produces one quotient bit per stage; a new division may enter every cycle.
// The side-band word travels alongside the operands.
// ----------------------------------------------------------------------------
module ccm_divider #(
    parameter int NUM_W  = 41,
    parameter int DEN_W  = 25,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              c_vld;
        logic [NUM_W-1:0]  c_num;
        logic [DEN_W:0]    c_rem;
        logic [DEN_W-1:0]  c_den;
        logic [SIDE_W-1:0] c_side;
        logic              r_vld;
        logic [NUM_W-1:0]  r_num;
        logic [DEN_W:0]    r_rem;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;
        logic [DEN_W+1:0]  n_trial;
        logic [DEN_W:0]    n_rem;
        logic              n_bit;

        // The first stage takes the operands straight from the ports.
        if (k == 0) begin : g_head
            assign c_vld  = i_valid;
            assign c_num  = i_num;
            assign c_rem  = '0;
            assign c_den  = i_den;
            assign c_side = i_side;
        end else begin : g_tail
            assign c_vld  = g_stage[k-1].r_vld;
            assign c_num  = g_stage[k-1].r_num;
            assign c_rem  = g_stage[k-1].r_rem;
            assign c_den  = g_stage[k-1].r_den;
            assign c_side = g_stage[k-1].r_side;
        end

        always_comb begin
            n_trial = {c_rem, c_num[NUM_W-1]};
            n_bit   = n_trial >= {2'b00, c_den};
            n_rem   = n_bit ? (DEN_W+1)'(n_trial - {2'b00, c_den})
                            : n_trial[DEN_W:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= c_vld;
            end
            r_num  <= {c_num[NUM_W-2:0], n_bit};
            r_rem  <= n_rem;
            r_den  <= c_den;
            r_side <= c_side;
        end
    end

    assign o_valid = g_stage[NUM_W-1].r_vld;
    assign o_quot  = g_stage[NUM_W-1].r_num;
    assign o_side  = g_stage[NUM_W-1].r_side;
endmodule

/* src/ccm_complement.sv */
// ----------------------------------------------------------------------------
// ccm_complement: pastel complement pipeline with saturated-probe passthrough
// Saturates the probe, derives hue and lightness, turns the hue by a half,
// rebuilds RGB at fixed saturation and applies the pastel clamp.
// ----------------------------------------------------------------------------
module ccm_complement #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ccm_pkg::t_request    i_req,
    output logic                 o_valid,
    output logic [FRACTION_BITS:0] o_red,
    output logic [FRACTION_BITS:0] o_green,
    output logic [FRACTION_BITS:0] o_blue
);
    import ccm_pkg::*;

    localparam int C_W = FRACTION_BITS + 1;
    localparam int H_W = FRACTION_BITS + 4;
    localparam int T_W = FRACTION_BITS + 5;
    localparam int N_W = 2 * FRACTION_BITS + 1;
    localparam logic [C_W-1:0] ONE = C_W'(1) << FRACTION_BITS;
    localparam logic [C_W-1:0] LO  = C_W'((4 * (64'd1 << FRACTION_BITS) + 2) / 5);
    localparam logic [C_W-1:0] SAT = C_W'((3 * (64'd1 << FRACTION_BITS) + 5) / 10);
    localparam logic [H_W-1:0] ONE_H = H_W'(1) << FRACTION_BITS;
    // Side band: passthrough color, complement flag, base, sign, grey, lightness
    localparam int SIDE_W = 3 * C_W + 1 + 3 + 1 + 1 + C_W;

    function automatic logic [C_W-1:0] sat1(input logic [FIELD_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(ONE)) ? ONE : w[C_W-1:0];
    endfunction

    // Stage 1: saturate, max/min, sector, numerator.
    logic [C_W-1:0] s_r, s_g, s_b, s_mx, s_mn, s_a, s_b2;
    logic [2:0]     s_base;
    logic           s_neg;
    always_comb begin
        s_r = sat1(i_req.probe_red);
        s_g = sat1(i_req.probe_green);
        s_b = sat1(i_req.probe_blue);
        s_mx = s_r;
        if (s_g > s_mx) s_mx = s_g;
        if (s_b > s_mx) s_mx = s_b;
        s_mn = s_r;
        if (s_g < s_mn) s_mn = s_g;
        if (s_b < s_mn) s_mn = s_b;
        if (s_mx == s_r) begin
            s_a = s_g; s_b2 = s_b; s_base = (s_g >= s_b) ? 3'd0 : 3'd6;
        end else if (s_mx == s_g) begin
            s_a = s_b; s_b2 = s_r; s_base = 3'd2;
        end else begin
            s_a = s_r; s_b2 = s_g; s_base = 3'd4;
        end
        s_neg = s_a < s_b2;
    end

    logic                 r1_vld;
    logic [N_W-1:0]       r1_num;
    logic [C_W-1:0]       r1_den;
    logic [SIDE_W-1:0]    r1_side;
    logic [C_W-1:0]       n1_l, n1_diff;
    always_comb begin
        n1_l    = C_W'(({1'b0, s_mx} + {1'b0, s_mn}) >> 1);
        n1_diff = s_neg ? (s_b2 - s_a) : (s_a - s_b2);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
        r1_num  <= {n1_diff, {FRACTION_BITS{1'b0}}};
        r1_den  <= (s_mx == s_mn) ? C_W'(1) : (s_mx - s_mn);
        r1_side <= {s_r, s_g, s_b, i_req.use_complement, s_base, s_neg,
                    s_mx == s_mn, n1_l};
    end

    logic                 d_vld;
    logic [N_W-1:0]       d_quot;
    logic [SIDE_W-1:0]    d_side;
    ccm_divider #(.NUM_W(N_W), .DEN_W(C_W), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_vld),
        .i_num   (r1_num),
        .i_den   (r1_den),
        .i_side  (r1_side),
        .o_valid (d_vld),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    // Stage after divide: hue, turned hue, lightness clamp, q and p.
    logic [C_W-1:0] x_r, x_g, x_b, x_l;
    logic           x_cmp, x_neg, x_grey;
    logic [2:0]     x_base;
    logic [H_W-1:0] x_hue;
    logic [C_W-1:0] x_lc;
    logic [2*C_W-1:0] x_prod;
    always_comb begin
        {x_r, x_g, x_b, x_cmp, x_base, x_neg, x_grey, x_l} = d_side;
        if (x_grey) begin
            x_hue = '0;
        end else if (x_neg) begin
            x_hue = H_W'(x_base) * ONE_H - H_W'(d_quot);
        end else begin
            x_hue = H_W'(x_base) * ONE_H + H_W'(d_quot);
        end
        x_hue = x_hue + H_W'(3 * ONE_H);
        if (x_hue > 6 * ONE_H) x_hue = x_hue - H_W'(6 * ONE_H);
        x_lc = (x_l < LO) ? LO : ((x_l > ONE) ? ONE : x_l);
        x_prod = x_lc * SAT;
    end

    logic                 r2_vld;
    logic [H_W-1:0]       r2_hue;
    logic [C_W-1:0]       r2_q, r2_p;
    logic [3*C_W:0]       r2_pass;
    logic [C_W:0]         n2_q;
    always_comb begin
        n2_q = {1'b0, x_lc} + {1'b0, SAT} - (C_W+1)'(x_prod >> FRACTION_BITS);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= d_vld;
        end
        r2_hue  <= x_hue;
        r2_q    <= n2_q[C_W-1:0];
        r2_p    <= C_W'({x_lc, 1'b0} - n2_q);
        r2_pass <= {x_cmp, x_r, x_g, x_b};
    end

    // Ramp stage: pick fraction per channel, multiply, register.
    typedef struct packed {
        logic           lin;
        logic           full;
        logic [C_W-1:0] x;
    } t_ramp;

    function automatic t_ramp ramp_sel(input logic signed [T_W-1:0] t_in);
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] one;
        t_ramp o;
        one = T_W'(ONE_H);
        t = t_in;
        if (t < 0) t = t + T_W'(6 * one);
        if (t > 6 * one) t = t - T_W'(6 * one);
        o = '0;
        if (t < one) begin
            o.lin = 1'b1; o.x = C_W'(t);
        end else if (t < 3 * one) begin
            o.full = 1'b1;
        end else if (t < 4 * one) begin
            o.lin = 1'b1; o.x = C_W'(4 * one - t);
        end
        return o;
    endfunction

    t_ramp m_sel [3];
    logic [C_W-1:0] m_span;
    always_comb begin
        m_sel[0] = ramp_sel(T_W'(r2_hue) + T_W'(2 * ONE_H));
        m_sel[1] = ramp_sel(T_W'(r2_hue));
        m_sel[2] = ramp_sel(T_W'(r2_hue) - T_W'(2 * ONE_H));
        m_span   = r2_q - r2_p;
    end

    logic                 r3_vld;
    logic [2*C_W-1:0]     r3_prod [3];
    t_ramp                r3_sel  [3];
    logic [C_W-1:0]       r3_q, r3_p;
    logic [3*C_W:0]       r3_pass;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        for (int k = 0; k < 3; k++) begin
            r3_prod[k] <= m_span * m_sel[k].x;
            r3_sel[k]  <= m_sel[k];
        end
        r3_q    <= r2_q;
        r3_p    <= r2_p;
        r3_pass <= r2_pass;
    end

    // Final stage: channel values, pastel clamp, select output.
    logic [C_W-1:0] f_c [3];
    logic [C_W-1:0] f_o [3];
    logic [C_W-1:0] f_m;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r3_sel[k].lin) begin
                f_c[k] = r3_p + C_W'(r3_prod[k] >> FRACTION_BITS);
            end else if (r3_sel[k].full) begin
                f_c[k] = r3_q;
            end else begin
                f_c[k] = r3_p;
            end
        end
        f_m = f_c[0];
        if (f_c[1] > f_m) f_m = f_c[1];
        if (f_c[2] > f_m) f_m = f_c[2];
        for (int k = 0; k < 3; k++) begin
            if (f_c[k] == f_m)     f_o[k] = ONE;
            else if (f_c[k] < LO)  f_o[k] = LO;
            else if (f_c[k] > ONE) f_o[k] = ONE;
            else                   f_o[k] = f_c[k];
        end
    end

    logic           r4_vld;
    logic [C_W-1:0] r4_r, r4_g, r4_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_r <= r3_pass[3*C_W] ? f_o[0] : r3_pass[3*C_W-1:2*C_W];
        r4_g <= r3_pass[3*C_W] ? f_o[1] : r3_pass[2*C_W-1:C_W];
        r4_b <= r3_pass[3*C_W] ? f_o[2] : r3_pass[C_W-1:0];
    end

    assign o_valid = r4_vld;
    assign o_red   = r4_r;
    assign o_green = r4_g;
    assign o_blue  = r4_b;
endmodule

/* src/ccm_distance.sv */
// ----------------------------------------------------------------------------
// ccm_distance: weighted distance compare
// Squares the channel differences, weights them and compares against the
// squared tolerance.
// ----------------------------------------------------------------------------
module ccm_distance #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [FRACTION_BITS:0] i_red,
    input  logic [FRACTION_BITS:0] i_green,
    input  logic [FRACTION_BITS:0] i_blue,
    input  logic [FRACTION_BITS:0] i_ref_red,
    input  logic [FRACTION_BITS:0] i_ref_green,
    input  logic [FRACTION_BITS:0] i_ref_blue,
    input  logic [16:0]            i_tolerance,
    output logic                   o_valid,
    output ccm_pkg::t_result       o_result
);
    import ccm_pkg::*;

    localparam int C_W = FRACTION_BITS + 1;
    localparam int S_W = 2 * C_W;
    localparam int D_W = S_W + 12;

    function automatic logic [C_W-1:0] absdiff(input logic [C_W-1:0] a,
                                               input logic [C_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic           r1_vld;
    logic [C_W-1:0] r1_d [3];
    logic [C_W-1:0] r1_c [3];
    logic [16:0]    r1_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
        r1_d[0] <= absdiff(i_red, i_ref_red);
        r1_d[1] <= absdiff(i_green, i_ref_green);
        r1_d[2] <= absdiff(i_blue, i_ref_blue);
        r1_c[0] <= i_red;
        r1_c[1] <= i_green;
        r1_c[2] <= i_blue;
        r1_tol  <= i_tolerance;
    end

    logic           r2_vld;
    logic [S_W-1:0] r2_sq [3];
    logic [33:0]    r2_tsq;
    logic [C_W-1:0] r2_c [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int k = 0; k < 3; k++) begin
            r2_sq[k] <= r1_d[k] * r1_d[k];
            r2_c[k]  <= r1_c[k];
        end
        r2_tsq <= r1_tol * r1_tol;
    end

    logic           r3_vld;
    logic [D_W-1:0] r3_w [3];
    logic [43:0]    r3_lim;
    logic [C_W-1:0] r3_c [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_w[0] <= D_W'(r2_sq[0]) * D_W'(299);
        r3_w[1] <= D_W'(r2_sq[1]) * D_W'(587);
        r3_w[2] <= D_W'(r2_sq[2]) * D_W'(114);
        r3_lim  <= 44'(r2_tsq) * 44'd1000;
        for (int k = 0; k < 3; k++) r3_c[k] <= r2_c[k];
    end

    logic [D_W+1:0] n_sum;
    logic           n_match;
    always_comb begin
        n_sum   = (D_W+2)'(r3_w[0]) + (D_W+2)'(r3_w[1]) + (D_W+2)'(r3_w[2]);
        n_match = ((D_W > 44) ? 64'(n_sum) : 64'(n_sum)) <= 64'(r3_lim);
    end

    logic    r4_vld;
    t_result r4_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_res.is_match      <= n_match;
        r4_res.checked_red   <= FIELD_W'(r3_c[0]);
        r4_res.checked_green <= FIELD_W'(r3_c[1]);
        r4_res.checked_blue  <= FIELD_W'(r3_c[2]);
    end

    assign o_valid  = r4_vld;
    assign o_result = r4_res;
endmodule

/* src/complementary_color_match_top.sv */
// ----------------------------------------------------------------------------
// complementary_color_match_top: pastel complementary color matcher
// Optionally swaps a probe color for its pastel complement and tests its
// weighted distance to a stored reference color.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                              Handshake
//  --------  ---------------------------------  ------------------------------
//  request   i_start, o_busy, i_request         taken when i_start && !o_busy
//  result    o_done, o_result                   one-cycle strobe, no stall
//  config    i_cfg_we, i_cfg_index, i_cfg_data  written when i_cfg_we is high
//
// A request enters every cycle; o_busy is tied low because the pipeline never
// stalls. The hue divider is a one-bit-per-stage chain, with eight register
// stages around it. Reset clears every valid bit and restores the register
// defaults.
module complementary_color_match_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  ccm_pkg::t_request  i_request,
    output logic               o_done,
    output ccm_pkg::t_result   o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import ccm_pkg::*;

    localparam int C_W = FRACTION_BITS + 1;
    localparam logic [C_W-1:0] ONE = C_W'(1) << FRACTION_BITS;

    // Configuration registers, stored as written.
    logic [16:0] r_ref_red, r_ref_green, r_ref_blue, r_tolerance;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_red   <= '0;
            r_ref_green <= '0;
            r_ref_blue  <= '0;
            r_tolerance <= TOLERANCE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REF_RED:   r_ref_red   <= i_cfg_data;
                CFG_REF_GREEN: r_ref_green <= i_cfg_data;
                CFG_REF_BLUE:  r_ref_blue  <= i_cfg_data;
                CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The reference is saturated to one before use.
    function automatic logic [C_W-1:0] sat1(input logic [16:0] v);
        return (64'(v) > 64'(ONE)) ? ONE : C_W'(v);
    endfunction

    assign o_busy = 1'b0;

    logic           c_vld;
    logic [C_W-1:0] c_red, c_green, c_blue;
    ccm_complement #(.FRACTION_BITS(FRACTION_BITS)) u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_req   (i_request),
        .o_valid (c_vld),
        .o_red   (c_red),
        .o_green (c_green),
        .o_blue  (c_blue)
    );

    ccm_distance #(.FRACTION_BITS(FRACTION_BITS)) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (c_vld),
        .i_red       (c_red),
        .i_green     (c_green),
        .i_blue      (c_blue),
        .i_ref_red   (sat1(r_ref_red)),
        .i_ref_green (sat1(r_ref_green)),
        .i_ref_blue  (sat1(r_ref_blue)),
        .i_tolerance (r_tolerance),
        .o_valid     (o_done),
        .o_result    (o_result)
    );
endmodule

/* src/ccm_checker.sv */
// ----------------------------------------------------------------------------
// ccm_checker: port-level checks for the color matcher
// Watches the top level's ports and flags results that break its contract.
// ----------------------------------------------------------------------------
module ccm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_busy,
    input logic              o_done,
    input ccm_pkg::t_result  o_result
);
    import ccm_pkg::*;

    // The pipeline never pushes back on requests.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    // No result may appear right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done) else $error("result right after reset");

    // A result never carries a component above one at the default width.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.checked_red <= 17'd65536
                 && o_result.checked_green <= 17'd65536
                 && o_result.checked_blue <= 17'd65536))
        else $error("component out of range");
endmodule

bind complementary_color_match_top ccm_checker u_ccm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
